### rtl/core/iau_pkg.sv
package iau_pkg;

  // Default operand width
  localparam int unsigned DataWidth = 32;

  // Operation codes as they arrive on the kind field
  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_REM  = 3'd4,
    KIND_POW  = 3'd5,
    KIND_SQRT = 3'd6
  } iau_kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDSUB,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_POW,
    ST_DONE
  } iau_state_e;

endpackage

### rtl/core/iau_addsub.sv
module iau_addsub #(
  parameter int unsigned WIDTH = iau_pkg::DataWidth + 1
) (
  input  logic [WIDTH-1:0] op_a_i,
  input  logic [WIDTH-1:0] op_b_i,
  input  logic             sub_i,
  output logic [WIDTH-1:0] sum_o
);

  logic [WIDTH-1:0] op_b_inv;

  // Invert the second operand and inject the carry for subtraction
  assign op_b_inv = op_b_i ^ {WIDTH{sub_i}};
  assign sum_o    = op_a_i + op_b_inv + WIDTH'(sub_i);

endmodule

### rtl/core/integer_arith_unit_pow_isqrt.sv
// Integer arithmetic unit: add, subtract, multiply (wrapping), divide toward zero,
// remainder with the dividend's sign, integer power and floor square root, all on
// DATA_WIDTH-bit two's-complement operands, one result beat per input beat. A single
// (DATA_WIDTH+1)-bit adder/subtractor does the add, subtract and iterative steps under a
// small sequencer, and the block takes no new beat until the current one is finished.
// Multiply is shift-add, one multiplier bit a cycle, ending early when the remaining
// multiplier bits are zero; divide and remainder are restoring, one quotient bit a cycle;
// square root takes two input bits a cycle. Power runs square-and-multiply through the
// same serial multiplier. Error cases (zero divisor, negative exponent, negative root
// input) finish with value 0. A finished result waits in the output register while the
// next beat is already accepted.
module integer_arith_unit_pow_isqrt #(
  parameter int unsigned DATA_WIDTH = iau_pkg::DataWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   kind_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] value_o,
  output logic                         error_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned NW = W + (W % 2);
  localparam int unsigned CW = $clog2(W + 1);

  iau_pkg::iau_state_e state_q, state_d;
  iau_pkg::iau_kind_e  kind_q, kind_d;
  iau_pkg::iau_kind_e  kind_in;

  logic [W-1:0]  acc_q, acc_d;
  logic [W-1:0]  m_q, m_d;
  logic [W-1:0]  x_q, x_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [NW-1:0] sq_n_q, sq_n_d;
  logic [W-1:0]  pw_acc_q, pw_acc_d;
  logic [W-1:0]  pw_base_q, pw_base_d;
  logic [W-1:0]  pw_exp_q, pw_exp_d;
  logic          pw_phase_q, pw_phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic          err_q, err_d;
  logic          out_valid_q, out_valid_d;
  logic [W-1:0]  value_q, value_d;
  logic          error_q, error_d;

  logic [W:0]    add_a, add_b, add_sum;
  logic          add_sub;
  logic          borrow;
  logic [W-1:0]  a_u, b_u, a_mag, b_mag;
  logic [W-1:0]  res_src, res_val;
  logic          out_free;

  // Shared adder/subtractor
  iau_addsub #(
    .WIDTH (W + 1)
  ) u_addsub (
    .op_a_i (add_a),
    .op_b_i (add_b),
    .sub_i  (add_sub),
    .sum_o  (add_sum)
  );

  assign borrow   = add_sum[W];
  assign a_u      = operand_a_i;
  assign b_u      = operand_b_i;
  assign a_mag    = a_u[W-1] ? (~a_u + W'(1)) : a_u;
  assign b_mag    = b_u[W-1] ? (~b_u + W'(1)) : b_u;
  assign kind_in  = (kind_i > 3'(iau_pkg::KIND_SQRT)) ? iau_pkg::KIND_SQRT
                                                      : iau_pkg::iau_kind_e'(kind_i);
  assign out_free = !out_valid_q || out_ready_i;

  // Select the adder operands for the active step
  always_comb begin
    add_a   = {1'b0, x_q};
    add_b   = {1'b0, m_q};
    add_sub = 1'b0;
    unique case (state_q)
      iau_pkg::ST_ADDSUB: begin
        add_sub = (kind_q == iau_pkg::KIND_SUB);
      end
      iau_pkg::ST_MUL: begin
        add_a = {1'b0, acc_q};
      end
      iau_pkg::ST_DIV: begin
        add_a   = {rem_q[W-1:0], x_q[W-1]};
        add_sub = 1'b1;
      end
      iau_pkg::ST_SQRT: begin
        add_a   = {rem_q[W-2:0], sq_n_q[NW-1 -: 2]};
        add_b   = {acc_q[W-2:0], 2'b01};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Pick the finished result and fix its sign
  always_comb begin
    unique case (kind_q)
      iau_pkg::KIND_DIV: res_src = x_q;
      iau_pkg::KIND_REM: res_src = rem_q;
      iau_pkg::KIND_POW: res_src = pw_acc_q;
      default:           res_src = acc_q;
    endcase
    res_val = neg_q ? (~res_src + W'(1)) : res_src;
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    acc_d       = acc_q;
    m_d         = m_q;
    x_d         = x_q;
    rem_d       = rem_q;
    sq_n_d      = sq_n_q;
    pw_acc_d    = pw_acc_q;
    pw_base_d   = pw_base_q;
    pw_exp_d    = pw_exp_q;
    pw_phase_d  = pw_phase_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    err_d       = err_q;
    value_d     = value_q;
    error_d     = error_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    unique case (state_q)
      iau_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d = kind_in;
          neg_d  = 1'b0;
          err_d  = 1'b0;
          x_d    = a_u;
          m_d    = b_u;
          acc_d  = '0;
          rem_d  = '0;
          unique case (kind_in)
            iau_pkg::KIND_ADD, iau_pkg::KIND_SUB: begin
              state_d = iau_pkg::ST_ADDSUB;
            end
            iau_pkg::KIND_MUL: begin
              m_d     = a_u;
              x_d     = b_u;
              state_d = iau_pkg::ST_MUL;
            end
            iau_pkg::KIND_DIV, iau_pkg::KIND_REM: begin
              x_d   = a_mag;
              m_d   = b_mag;
              cnt_d = CW'(W);
              neg_d = (kind_in == iau_pkg::KIND_DIV) ? (a_u[W-1] ^ b_u[W-1]) : a_u[W-1];
              if (b_u == '0) begin
                err_d   = 1'b1;
                state_d = iau_pkg::ST_DONE;
              end else begin
                state_d = iau_pkg::ST_DIV;
              end
            end
            iau_pkg::KIND_POW: begin
              pw_acc_d   = W'(1);
              pw_base_d  = a_u;
              pw_exp_d   = b_u;
              pw_phase_d = 1'b0;
              if (b_u[W-1]) begin
                err_d   = 1'b1;
                state_d = iau_pkg::ST_DONE;
              end else begin
                state_d = iau_pkg::ST_POW;
              end
            end
            default: begin
              sq_n_d = NW'(a_u);
              cnt_d  = CW'(NW / 2);
              if (a_u[W-1]) begin
                err_d   = 1'b1;
                state_d = iau_pkg::ST_DONE;
              end else begin
                state_d = iau_pkg::ST_SQRT;
              end
            end
          endcase
        end
      end

      iau_pkg::ST_ADDSUB: begin
        acc_d   = add_sum[W-1:0];
        state_d = iau_pkg::ST_DONE;
      end

      // Shift-add multiply, one multiplier bit a cycle; also serves the power steps
      iau_pkg::ST_MUL: begin
        if (x_q == '0) begin
          if (kind_q == iau_pkg::KIND_MUL) begin
            state_d = iau_pkg::ST_DONE;
          end else if (!pw_phase_q) begin
            pw_acc_d   = acc_q;
            pw_phase_d = 1'b1;
            state_d    = iau_pkg::ST_POW;
          end else begin
            pw_base_d  = acc_q;
            pw_exp_d   = pw_exp_q >> 1;
            pw_phase_d = 1'b0;
            state_d    = iau_pkg::ST_POW;
          end
        end else begin
          if (x_q[0]) begin
            acc_d = add_sum[W-1:0];
          end
          m_d = m_q << 1;
          x_d = x_q >> 1;
        end
      end

      // Restoring divide, one quotient bit a cycle
      iau_pkg::ST_DIV: begin
        rem_d = borrow ? add_a[W-1:0] : add_sum[W-1:0];
        x_d   = {x_q[W-2:0], ~borrow};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = iau_pkg::ST_DONE;
        end
      end

      // Digit-by-digit root, two input bits a cycle
      iau_pkg::ST_SQRT: begin
        rem_d  = borrow ? add_a[W-1:0] : add_sum[W-1:0];
        acc_d  = {acc_q[W-2:0], ~borrow};
        sq_n_d = sq_n_q << 2;
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = iau_pkg::ST_DONE;
        end
      end

      // Square-and-multiply: phase 0 folds the base in, phase 1 squares it
      iau_pkg::ST_POW: begin
        if (!pw_phase_q) begin
          if (pw_exp_q == '0) begin
            state_d = iau_pkg::ST_DONE;
          end else if (pw_exp_q[0]) begin
            acc_d   = '0;
            m_d     = pw_acc_q;
            x_d     = pw_base_q;
            state_d = iau_pkg::ST_MUL;
          end else begin
            pw_phase_d = 1'b1;
          end
        end else if (pw_exp_q[W-1:1] == '0) begin
          pw_exp_d   = '0;
          pw_phase_d = 1'b0;
        end else begin
          acc_d   = '0;
          m_d     = pw_base_q;
          x_d     = pw_base_q;
          state_d = iau_pkg::ST_MUL;
        end
      end

      // Hand the result to the output register once it is free
      iau_pkg::ST_DONE: begin
        if (out_free) begin
          value_d     = err_q ? '0 : res_val;
          error_d     = err_q;
          out_valid_d = 1'b1;
          state_d     = iau_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = iau_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iau_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    acc_q      <= acc_d;
    m_q        <= m_d;
    x_q        <= x_d;
    rem_q      <= rem_d;
    sq_n_q     <= sq_n_d;
    pw_acc_q   <= pw_acc_d;
    pw_base_q  <= pw_base_d;
    pw_exp_q   <= pw_exp_d;
    pw_phase_q <= pw_phase_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    err_q      <= err_d;
    value_q    <= value_d;
    error_q    <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign error_o     = error_q;

  // An error result always carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> value_o == '0)
    else $error("error result with nonzero value");

  // Iterative divide and root never run with an exhausted step count
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iau_pkg::ST_DIV || state_q == iau_pkg::ST_SQRT) |-> cnt_q != '0)
    else $error("step counter exhausted while iterating");

  // An accepted add or subtract goes straight to the adder step
  a_addsub_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == 3'(iau_pkg::KIND_ADD) ||
    kind_i == 3'(iau_pkg::KIND_SUB)) |=> state_q == iau_pkg::ST_ADDSUB)
    else $error("add or subtract did not enter the adder step");

  // A finished result with a free output slot is presented next cycle
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == iau_pkg::ST_DONE && out_free |=> out_valid_o && state_q == iau_pkg::ST_IDLE)
    else $error("finished result not moved to the output register");

endmodule

### dv/tb_integer_arith_unit_pow_isqrt.sv
`timescale 1ns / 1ps

module tb_integer_arith_unit_pow_isqrt;
  import iau_pkg::*;

  localparam int unsigned Dw = DataWidth;
  // Code 7 has no name in the package and falls through to square root
  localparam logic [2:0] KindSpare = 3'd7;
  localparam logic signed [Dw-1:0] MaxVal = {1'b0, {(Dw-1){1'b1}}};
  localparam logic signed [Dw-1:0] MinVal = {1'b1, {(Dw-1){1'b0}}};

  typedef struct packed {
    logic signed [Dw-1:0] value;
    logic                 error;
  } arith_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [2:0]           kind_i = KIND_ADD;
  logic signed [Dw-1:0] operand_a_i = '0;
  logic signed [Dw-1:0] operand_b_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [Dw-1:0] value_o;
  logic                 error_o;

  arith_result_t pending_results[$];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            mismatch_count = 0;
  int            results_checked = 0;
  int            error_results = 0;
  int            beats_per_kind[8];

  integer_arith_unit_pow_isqrt #(
    .DATA_WIDTH(Dw)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .error_o    (error_o)
  );

  always #2 clk_i = ~clk_i;

  // Work out the value and error flag that one operation must give
  function automatic arith_result_t compute_result(input logic [2:0] kind,
                                                   input logic signed [Dw-1:0] a,
                                                   input logic signed [Dw-1:0] b);
    arith_result_t r;
    logic [Dw-1:0] mag_a, mag_b, quo, rmd, base, acc, expo, rest, root, bitv;
    r.value = '0;
    r.error = 1'b0;
    case (kind)
      KIND_ADD: r.value = a + b;
      KIND_SUB: r.value = a - b;
      KIND_MUL: r.value = a * b;
      KIND_DIV, KIND_REM: begin
        if (b == 0) begin
          r.error = 1'b1;
        end else begin
          // Work on magnitudes; the most negative value maps to 2^(Dw-1) unsigned
          mag_a = a[Dw-1] ? -a : a;
          mag_b = b[Dw-1] ? -b : b;
          if (kind == KIND_DIV) begin
            quo = mag_a / mag_b;
            r.value = (a[Dw-1] ^ b[Dw-1]) ? -quo : quo;
          end else begin
            rmd = mag_a % mag_b;
            r.value = a[Dw-1] ? -rmd : rmd;
          end
        end
      end
      KIND_POW: begin
        if (b[Dw-1]) begin
          r.error = 1'b1;
        end else begin
          // Square and multiply, wrapping at the operand width
          acc  = 1;
          base = a;
          expo = b;
          for (int i = 0; i < Dw; i++) begin
            if (expo[0]) acc = acc * base;
            base = base * base;
            expo = expo >> 1;
          end
          r.value = acc;
        end
      end
      default: begin
        // Square root, also for the spare code
        if (a[Dw-1]) begin
          r.error = 1'b1;
        end else begin
          rest = a;
          root = '0;
          bitv = {2'b01, {(Dw-2){1'b0}}};
          while (bitv > rest) bitv = bitv >> 2;
          while (bitv != 0) begin
            if (rest >= root + bitv) begin
              rest = rest - (root + bitv);
              root = (root >> 1) + bitv;
            end else begin
              root = root >> 1;
            end
            bitv = bitv >> 2;
          end
          r.value = root;
        end
      end
    endcase
    return r;
  endfunction

  // Hold one beat on the input until it is accepted, with random idle cycles first
  task automatic send_beat(input logic [2:0] kind, input logic signed [Dw-1:0] a,
                           input logic signed [Dw-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    operand_a_i <= a;
    operand_b_i <= b;
    pending_results.push_back(compute_result(kind, a, b));
    beats_per_kind[kind]++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic end_burst();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Operand mix: corner values, small values and full-range values
  function automatic logic signed [Dw-1:0] pick_operand();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return '0;
          1: return 1;
          2: return -1;
          3: return MaxVal;
          default: return MinVal;
        endcase
      end
      1, 2: return $signed($urandom_range(32)) - 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_wrapping_arith();
    send_beat(KIND_ADD, MaxVal, 1);
    send_beat(KIND_ADD, MinVal, -1);
    send_beat(KIND_SUB, MinVal, 1);
    send_beat(KIND_SUB, 0, MinVal);
    send_beat(KIND_MUL, MaxVal, MaxVal);
    send_beat(KIND_MUL, MinVal, -1);
    end_burst();
  endtask

  task automatic test_divide_remainder();
    send_beat(KIND_DIV, 7, -2);
    send_beat(KIND_DIV, MinVal, -1);
    send_beat(KIND_DIV, MaxVal, 0);
    send_beat(KIND_REM, -7, 2);
    send_beat(KIND_REM, MinVal, -1);
    send_beat(KIND_REM, 5, 0);
    end_burst();
  endtask

  task automatic test_power();
    send_beat(KIND_POW, 0, 0);
    send_beat(KIND_POW, -3, 5);
    send_beat(KIND_POW, 2, Dw - 1);
    send_beat(KIND_POW, 2, -1);
    send_beat(KIND_POW, 3, MaxVal);
    end_burst();
  endtask

  task automatic test_square_root();
    send_beat(KIND_SQRT, MaxVal, 0);
    send_beat(KIND_SQRT, 0, MinVal);
    send_beat(KIND_SQRT, -1, 0);
    send_beat(KIND_SQRT, MinVal, 0);
    send_beat(KIND_SQRT, 15, $urandom);
    send_beat(KindSpare, 16, $urandom);
    send_beat(KindSpare, -16, 0);
    end_burst();
  endtask

  // Random mix of all codes; slow power exponents stay rare
  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    logic [2:0]           kind;
    logic signed [Dw-1:0] a, b;
    int                   k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      a = pick_operand();
      b = pick_operand();
      case ($urandom_range(15))
        0, 1: kind = KIND_ADD;
        2, 3: kind = KIND_SUB;
        4, 5: kind = KIND_MUL;
        6, 7: kind = KIND_DIV;
        8, 9: kind = KIND_REM;
        10, 11: kind = KIND_POW;
        12, 13, 14: kind = KIND_SQRT;
        default: kind = KindSpare;
      endcase
      if (kind == KIND_DIV || kind == KIND_REM) begin
        case ($urandom_range(11))
          0: b = '0;
          1: begin
            a = MinVal;
            b = -1;
          end
          2, 3: b = $signed($urandom_range(16)) - 8;
          default: ;
        endcase
      end else if (kind == KIND_POW) begin
        if ($urandom_range(1) == 0) a = $signed($urandom_range(8)) - 4;
        case ($urandom_range(15))
          0: b = $urandom | {1'b1, {(Dw-1){1'b0}}};
          1: b = $urandom >> 1;
          default: b = $urandom_range(20);
        endcase
      end else if (kind == KIND_SQRT || kind == KindSpare) begin
        case ($urandom_range(7))
          0: a = $urandom | {1'b1, {(Dw-1){1'b0}}};
          1, 2: begin
            k = $urandom_range(46340);
            a = k * k + $signed($urandom_range(2)) - 1;
          end
          default: a = ($urandom >> $urandom_range(31)) & MaxVal;
        endcase
        b = $urandom;
      end
      send_beat(kind, a, b);
    end
    end_burst();
  endtask

  task automatic report_mismatch(input string what, input arith_result_t exp_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s: expected value %0d error %0b, got value %0d error %0b",
               $realtime, what, exp_r.value, exp_r.error, value_o, error_o);
    end
  endtask

  // Randomly stall the result side
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : check_results
    arith_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (error_o) error_results++;
      if (pending_results.size() == 0) begin
        exp_r = '0;
        report_mismatch("result beat with nothing expected", exp_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (value_o !== exp_r.value || error_o !== exp_r.error) begin
          report_mismatch("wrong result", exp_r);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_wrapping_arith();
    test_divide_remainder();
    test_power();
    test_square_root();
    test_random_traffic(367, 29, 87);
    test_random_traffic(367, 87, 29);
    test_random_traffic(367, 0, 0);

    // Let any stray beat show up before closing
    repeat (60) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
    end
    $display("summary: %0d results checked, %0d with error flag, %0d mismatches",
             results_checked, error_results, mismatch_count);
    $display("summary: beats add %0d sub %0d mul %0d div %0d rem %0d pow %0d sqrt %0d spare %0d",
             beats_per_kind[0], beats_per_kind[1], beats_per_kind[2], beats_per_kind[3],
             beats_per_kind[4], beats_per_kind[5], beats_per_kind[6], beats_per_kind[7]);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule
